>>> rtl/hbe_pkg.sv
// shared constants and types for the huffman byte encoder
package hbe_pkg;

  localparam int BYTE_W = 8;
  localparam int PEND_W = 7;
  localparam int CODE_W = 32;
  localparam int LEN_W  = 6;
  localparam int SYM_W  = 8;
  localparam int KIND_W = 2;

  typedef enum logic [KIND_W-1:0] {
    KIND_LOAD   = 2'd0,
    KIND_ENCODE = 2'd1,
    KIND_FLUSH  = 2'd2
  } kind_t;

  // work item passed from the front to the back through the queue
  typedef struct packed {
    logic              flush;
    logic [CODE_W-1:0] code;
    logic [LEN_W-1:0]  len;
  } q_entry_t;

endpackage

>>> rtl/hbe_if.sv
// valid/ready channel interfaces for input items and output bytes
interface hbe_in_if;
  import hbe_pkg::*;
  logic              valid;
  logic              ready;
  logic [KIND_W-1:0] kind;
  logic [SYM_W-1:0]  symbol;
  logic [CODE_W-1:0] code_word;
  logic [LEN_W-1:0]  code_length;

  modport source (output valid, kind, symbol, code_word, code_length, input ready);
  modport sink   (input valid, kind, symbol, code_word, code_length, output ready);
endinterface

interface hbe_out_if;
  import hbe_pkg::*;
  logic              valid;
  logic              ready;
  logic [BYTE_W-1:0] out_byte;
  logic              last;

  modport source (output valid, out_byte, last, input ready);
  modport sink   (input valid, out_byte, last, output ready);
endinterface

>>> rtl/hbe_ram.sv
// generic single-port-write ram with registered read
module hbe_ram #(
  parameter int WIDTH = 38,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // registered read, held while not enabled
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

>>> rtl/hbe_fifo.sv
// short queue of work entries between front and back
module hbe_fifo #(
  parameter int DEPTH = 4
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              push,
  input  hbe_pkg::q_entry_t push_data,
  output logic              full,
  input  logic              pop,
  output hbe_pkg::q_entry_t head,
  output logic              empty
);
  import hbe_pkg::*;

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  q_entry_t           slots [DEPTH];
  logic [PTR_W-1:0]   wr_ptr;
  logic [PTR_W-1:0]   rd_ptr;
  logic [CNT_W-1:0]   count;
  logic               do_push;
  logic               do_pop;

  assign full    = (count == CNT_W'(DEPTH));
  assign empty   = (count == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign head    = slots[rd_ptr];

  // storage
  always_ff @(posedge clk) begin
    if (do_push) begin
      slots[wr_ptr] <= push_data;
    end
  end

  // pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr + PTR_W'(1);
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr + PTR_W'(1);
      end
      case ({do_push, do_pop})
        2'b10:   count <= count + CNT_W'(1);
        2'b01:   count <= count - CNT_W'(1);
        default: count <= count;
      endcase
    end
  end

endmodule

>>> rtl/hbe_front.sv
// front end: accepts items, keeps the code table, queues encode and flush work
module hbe_front #(
  parameter int MAX_CODE_LEN = 32,
  parameter int SYMBOL_COUNT = 256
) (
  input  logic              clk,
  input  logic              rst,
  hbe_in_if.sink            req,
  output logic              push,
  output hbe_pkg::q_entry_t push_data,
  input  logic              full
);
  import hbe_pkg::*;

  localparam int IDX_W = $clog2(SYMBOL_COUNT);
  localparam int RAM_W = CODE_W + LEN_W;

  logic                    accept;
  logic                    is_load;
  logic                    is_enc;
  logic                    is_flush;
  logic                    in_range;
  logic [IDX_W-1:0]        idx;
  logic [LEN_W-1:0]        len_sat;
  logic [CODE_W-1:0]       word_masked;
  logic                    ram_we;
  logic                    ram_re;
  logic [RAM_W-1:0]        ram_rdata;
  logic [SYMBOL_COUNT-1:0] entry_valid;
  logic                    hit;
  logic                    s1_valid;
  logic                    s1_flush;
  logic                    s1_adv;
  logic                    need_push;
  logic [CODE_W-1:0]       rd_code;
  logic [LEN_W-1:0]        rd_len;

  assign accept = req.valid && req.ready;

  // kind decode
  always_comb begin
    is_load  = 1'b0;
    is_enc   = 1'b0;
    is_flush = 1'b0;
    unique case (req.kind)
      KIND_LOAD:   is_load  = 1'b1;
      KIND_ENCODE: is_enc   = 1'b1;
      KIND_FLUSH:  is_flush = 1'b1;
      default:     ;
    endcase
  end

  // table index check and load-side length clamp and code mask
  assign in_range    = ({1'b0, req.symbol} < (SYM_W + 1)'(SYMBOL_COUNT));
  assign idx         = req.symbol[IDX_W-1:0];
  assign len_sat     = (req.code_length > LEN_W'(MAX_CODE_LEN)) ? LEN_W'(MAX_CODE_LEN)
                                                                 : req.code_length;
  assign word_masked = req.code_word & ~({CODE_W{1'b1}} << len_sat);

  assign ram_we = accept && is_load && in_range;
  assign ram_re = accept && is_enc && in_range;

  hbe_ram #(
    .WIDTH (RAM_W),
    .DEPTH (SYMBOL_COUNT)
  ) u_table (
    .clk   (clk),
    .we    (ram_we),
    .waddr (idx),
    .wdata ({len_sat, word_masked}),
    .re    (ram_re),
    .raddr (idx),
    .rdata (ram_rdata)
  );

  // per-entry written flags, an unwritten entry reads as absent
  always_ff @(posedge clk) begin
    if (rst) begin
      entry_valid <= '0;
    end else if (ram_we) begin
      entry_valid[idx] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (ram_re) begin
      hit <= entry_valid[idx];
    end
  end

  // lookup stage waiting for table data
  assign rd_code   = ram_rdata[CODE_W-1:0];
  assign rd_len    = hit ? ram_rdata[RAM_W-1:CODE_W] : '0;
  assign need_push = s1_flush || (rd_len != '0);
  assign s1_adv    = !s1_valid || !need_push || !full;
  assign req.ready = s1_adv;
  assign push      = s1_valid && need_push && !full;

  always_comb begin
    push_data.flush = s1_flush;
    push_data.code  = rd_code;
    push_data.len   = rd_len;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
      s1_flush <= 1'b0;
    end else if (s1_adv) begin
      s1_valid <= accept && (is_flush || (is_enc && in_range));
      s1_flush <= is_flush;
    end
  end

endmodule

>>> rtl/hbe_back.sv
// back end: bit accumulator that packs codes and emits one byte per cycle while rsp is ready
module hbe_back #(
  parameter int MAX_CODE_LEN = 32
) (
  input  logic              clk,
  input  logic              rst,
  input  hbe_pkg::q_entry_t head,
  input  logic              empty,
  output logic              pop,
  hbe_out_if.source         rsp
);
  import hbe_pkg::*;

  localparam int ACC_W = MAX_CODE_LEN + PEND_W;
  localparam int TOT_W = $clog2(ACC_W + 1);

  logic [ACC_W-1:0]  acc;
  logic [ACC_W-1:0]  acc_next;
  logic [TOT_W-1:0]  total;
  logic [TOT_W-1:0]  total_next;
  logic [TOT_W-1:0]  rem;
  logic [TOT_W-1:0]  t1;
  logic [TOT_W-1:0]  fl_shamt;
  logic [PEND_W-1:0] pend;
  logic [BYTE_W-1:0] emit_byte;
  logic [BYTE_W-1:0] flush_byte;
  logic              out_free;
  logic              emit;
  logic              t1_small;
  logic              take_enc;
  logic              take_fl;
  logic              fl_out;
  logic              out_valid;
  logic [BYTE_W-1:0] out_byte;
  logic              out_last;

  assign out_free = !out_valid || rsp.ready;

  // byte emission from the top of the accumulated bits
  assign rem       = total - TOT_W'(BYTE_W);
  assign emit      = (total >= TOT_W'(BYTE_W)) && out_free;
  assign emit_byte = BYTE_W'(acc >> rem);
  assign t1        = emit ? rem : total;
  assign t1_small  = (t1 < TOT_W'(BYTE_W));

  // leftover bits after this cycle's byte
  assign pend = PEND_W'(acc) & ~({PEND_W{1'b1}} << t1);

  // intake of the next queued entry
  assign take_enc = !empty && !head.flush && t1_small;
  assign take_fl  = !empty && head.flush && t1_small && !emit && out_free;
  assign pop      = take_enc || take_fl;
  assign fl_out   = take_fl && (t1 != '0);
  assign fl_shamt = TOT_W'(BYTE_W) - t1;
  assign flush_byte = BYTE_W'({1'b0, pend} << fl_shamt);

  always_comb begin
    acc_next   = acc;
    total_next = t1;
    if (take_enc) begin
      acc_next   = (ACC_W'(pend) << head.len) | ACC_W'(head.code);
      total_next = t1 + TOT_W'(head.len);
    end else if (take_fl) begin
      total_next = '0;
    end
  end

  // accumulator
  always_ff @(posedge clk) begin
    acc <= acc_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      total <= '0;
    end else begin
      total <= total_next;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else begin
      out_valid <= emit || fl_out || (out_valid && !rsp.ready);
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      out_byte <= emit_byte;
      out_last <= (rem < TOT_W'(BYTE_W));
    end else if (fl_out) begin
      out_byte <= flush_byte;
      out_last <= 1'b1;
    end
  end

  assign rsp.valid    = out_valid;
  assign rsp.out_byte = out_byte;
  assign rsp.last     = out_last;

endmodule

>>> rtl/huffman_byte_encoder_top.sv
// huffman byte encoder: code table front end, queue, and bit packing back end
// an accepted encode item passes the table read, the queue, the accumulator and the output register before rsp
// throughput: one item per cycle into the front unless a full queue stalls its lookup stage;
//   the back emits one byte per cycle while rsp is ready, takes the next queued encode
//   once fewer than 8 bits remain, and takes a flush once the bytes ahead of it are out
// reset: table entries read as absent at once through per-entry flags, no clearing pass;
//   the accumulator, queue and output register come up empty
module huffman_byte_encoder_top #(
  parameter int MAX_CODE_LEN = 32,
  parameter int SYMBOL_COUNT = 256,
  parameter int QUEUE_DEPTH  = 4
) (
  input  logic      clk,
  input  logic      rst,
  hbe_in_if.sink    req,
  hbe_out_if.source rsp
);
  import hbe_pkg::*;

  q_entry_t q_in;
  q_entry_t q_head;
  logic     q_push;
  logic     q_full;
  logic     q_pop;
  logic     q_empty;

  hbe_front #(
    .MAX_CODE_LEN (MAX_CODE_LEN),
    .SYMBOL_COUNT (SYMBOL_COUNT)
  ) u_front (
    .clk       (clk),
    .rst       (rst),
    .req       (req),
    .push      (q_push),
    .push_data (q_in),
    .full      (q_full)
  );

  hbe_fifo #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (q_push),
    .push_data (q_in),
    .full      (q_full),
    .pop       (q_pop),
    .head      (q_head),
    .empty     (q_empty)
  );

  hbe_back #(
    .MAX_CODE_LEN (MAX_CODE_LEN)
  ) u_back (
    .clk   (clk),
    .rst   (rst),
    .head  (q_head),
    .empty (q_empty),
    .pop   (q_pop),
    .rsp   (rsp)
  );

  // front never pushes into a full queue
  a_no_push_full: assert property (@(posedge clk) disable iff (rst) q_push |-> !q_full)
    else $error("queue push while full");

  // back never pops an empty queue
  a_no_pop_empty: assert property (@(posedge clk) disable iff (rst) q_pop |-> !q_empty)
    else $error("queue pop while empty");

  // no output byte right after reset
  a_reset_quiet: assert property (@(posedge clk) rst |=> !rsp.valid)
    else $error("output valid after reset");

  // an empty queue with no push leaves nothing to pop in the next cycle
  a_pop_needs_entry: assert property (@(posedge clk) disable iff (rst)
    (q_empty && !q_push) |=> !q_pop)
    else $error("pop without a queued entry");

endmodule

>>> tb/tb_huffman_byte_encoder_top.sv
// self-checking testbench for the huffman byte encoder with its own packing model
`timescale 1ns / 1ps

module tb_huffman_byte_encoder_top;
  import hbe_pkg::*;

  localparam int CODE_LEN_MAX = 32;
  localparam int TABLE_SIZE   = 256;
  localparam int CYCLE_LIMIT  = 300000;
  localparam int TAIL_CYCLES  = 20;
  localparam int LONG_HOLD    = 120;
  localparam logic [KIND_W-1:0] KIND_UNUSED = 2'd3;

  typedef struct {
    logic [KIND_W-1:0] kind;
    logic [SYM_W-1:0]  sym;
    logic [CODE_W-1:0] word;
    logic [LEN_W-1:0]  len;
  } enc_item_t;

  typedef struct packed {
    logic [BYTE_W-1:0] data;
    logic              last;
  } byte_res_t;

  logic clk = 1'b0;
  logic rst;

  hbe_in_if  req_if ();
  hbe_out_if rsp_if ();

  huffman_byte_encoder_top uut (
    .clk (clk),
    .rst (rst),
    .req (req_if),
    .rsp (rsp_if)
  );

  // model state: code table plus the leftover bit accumulator
  logic [CODE_W-1:0] code_tab [TABLE_SIZE];
  logic [LEN_W-1:0]  len_tab  [TABLE_SIZE];
  logic [PEND_W-1:0] carry_bits;
  logic [2:0]        carry_cnt;

  enc_item_t send_q [$];
  byte_res_t due_bytes [$];
  enc_item_t drv_item;
  byte_res_t got;

  int unsigned n_queued;
  int unsigned n_accepted;
  int unsigned errors;
  int unsigned cycle_cnt;
  int unsigned send_gap;
  int unsigned recv_gap;
  int unsigned hold_req_cnt;
  int unsigned hold_seen;
  logic        burst_mode;
  logic        in_taken;

  // clock
  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // gap length: mostly short, now and then long
  function automatic int unsigned gap_len();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 50) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 95) return $urandom_range(4, 10);
    return $urandom_range(20, 40);
  endfunction

  // predict the bytes one accepted item produces
  task automatic encode_bytes(input logic [KIND_W-1:0] kind, input logic [SYM_W-1:0] sym,
                              input logic [CODE_W-1:0] word, input logic [LEN_W-1:0] len);
    int unsigned l;
    int unsigned total;
    int unsigned nbytes;
    logic [CODE_W-1:0] code;
    logic [38:0] acc;
    logic [14:0] flush_w;
    byte_res_t r;
    case (kind)
      KIND_LOAD: begin
        code_tab[sym] = word;
        len_tab[sym]  = (len > CODE_LEN_MAX) ? LEN_W'(CODE_LEN_MAX) : len;
      end
      KIND_ENCODE: begin
        l = len_tab[sym];
        if (l != 0) begin
          code = code_tab[sym];
          if (l < 32) code = code & ((32'h1 << l) - 32'h1);
          acc = ({32'h0, carry_bits} << l) | {7'h0, code};
          total = carry_cnt + l;
          nbytes = total / 8;
          for (int i = 0; i < nbytes; i++) begin
            total -= 8;
            r.data = BYTE_W'(acc >> total);
            r.last = (i == nbytes - 1);
            due_bytes.push_back(r);
          end
          carry_bits = PEND_W'(acc & ((39'h1 << total) - 39'h1));
          carry_cnt  = 3'(total);
        end
      end
      KIND_FLUSH: begin
        if (carry_cnt != 0) begin
          flush_w = {8'h0, carry_bits} << (8 - carry_cnt);
          r.data = flush_w[7:0];
          r.last = 1'b1;
          due_bytes.push_back(r);
          carry_bits = '0;
          carry_cnt  = '0;
        end
      end
      default: begin
      end
    endcase
  endtask

  // watch the request side, feed accepted items to the model
  always @(posedge clk) begin
    if (rst) begin
      in_taken <= 1'b0;
      n_accepted <= 0;
      for (int i = 0; i < TABLE_SIZE; i++) begin
        code_tab[i] = '0;
        len_tab[i]  = '0;
      end
      carry_bits = '0;
      carry_cnt  = '0;
    end else begin
      in_taken <= req_if.valid && req_if.ready;
      if (req_if.valid && req_if.ready) begin
        encode_bytes(req_if.kind, req_if.symbol, req_if.code_word, req_if.code_length);
        n_accepted <= n_accepted + 1;
      end
    end
  end

  // drive request items at the falling edge
  always @(negedge clk) begin
    if (rst) begin
      req_if.valid <= 1'b0;
      send_gap <= 0;
    end else if (!req_if.valid || in_taken) begin
      if (send_gap != 0) begin
        req_if.valid <= 1'b0;
        send_gap <= send_gap - 1;
      end else if (send_q.size() != 0) begin
        drv_item = send_q.pop_front();
        req_if.valid       <= 1'b1;
        req_if.kind        <= drv_item.kind;
        req_if.symbol      <= drv_item.sym;
        req_if.code_word   <= drv_item.word;
        req_if.code_length <= drv_item.len;
        send_gap <= burst_mode ? 0 : gap_len();
      end else begin
        req_if.valid <= 1'b0;
      end
    end
  end

  // response ready: random stalls, plus a long hold on request
  always @(negedge clk) begin
    if (rst) begin
      rsp_if.ready <= 1'b0;
      recv_gap <= 0;
      hold_seen <= 0;
    end else if (hold_seen != hold_req_cnt) begin
      hold_seen <= hold_req_cnt;
      recv_gap <= LONG_HOLD;
      rsp_if.ready <= 1'b0;
    end else if (recv_gap != 0) begin
      recv_gap <= recv_gap - 1;
      rsp_if.ready <= 1'b0;
    end else begin
      rsp_if.ready <= 1'b1;
      recv_gap <= gap_len();
    end
  end

  // compare each output byte with the oldest prediction
  always @(posedge clk) begin
    if (!rst && rsp_if.valid && rsp_if.ready) begin
      if (due_bytes.size() == 0) begin
        $display("%0t: unexpected byte, expected none, actual out_byte %02h last %b",
                 $time, rsp_if.out_byte, rsp_if.last);
        errors++;
      end else begin
        got = due_bytes.pop_front();
        if (rsp_if.out_byte !== got.data) begin
          $display("%0t: out_byte mismatch, expected %02h actual %02h",
                   $time, got.data, rsp_if.out_byte);
          errors++;
        end
        if (rsp_if.last !== got.last) begin
          $display("%0t: last mismatch, expected %b actual %b", $time, got.last, rsp_if.last);
          errors++;
        end
      end
    end
  end

  // run limit
  always @(posedge clk) begin
    cycle_cnt++;
    if (cycle_cnt > CYCLE_LIMIT) begin
      $display("FAILURE");
      $finish;
    end
  end

  task automatic queue_item(input logic [KIND_W-1:0] kind, input logic [SYM_W-1:0] sym,
                            input logic [CODE_W-1:0] word, input logic [LEN_W-1:0] len);
    enc_item_t it;
    it.kind = kind;
    it.sym  = sym;
    it.word = word;
    it.len  = len;
    send_q.push_back(it);
    n_queued++;
  endtask

  // random item: mostly encodes of a small symbol pool, some loads and flushes, a few unused kinds
  task automatic queue_random_item();
    int unsigned r;
    int unsigned rl;
    logic [SYM_W-1:0] sym;
    logic [LEN_W-1:0] len;
    r = $urandom_range(0, 99);
    sym = ($urandom_range(0, 3) == 0) ? SYM_W'($urandom_range(0, 255))
                                      : SYM_W'($urandom_range(0, 15));
    if (r < 18) begin
      rl = $urandom_range(0, 99);
      if (rl < 60) len = LEN_W'($urandom_range(1, 32));
      else if (rl < 80) len = LEN_W'($urandom_range(1, 8));
      else if (rl < 90) len = '0;
      else len = LEN_W'($urandom_range(33, 63));
      queue_item(KIND_LOAD, sym, $urandom, len);
    end else if (r < 80) begin
      queue_item(KIND_ENCODE, sym, $urandom, LEN_W'($urandom_range(0, 63)));
    end else if (r < 95) begin
      queue_item(KIND_FLUSH, sym, $urandom, LEN_W'($urandom_range(0, 63)));
    end else begin
      queue_item(KIND_UNUSED, sym, $urandom, LEN_W'($urandom_range(0, 63)));
    end
  endtask

  // wait until all items are taken and every predicted byte has come out
  task automatic wait_drained();
    while (n_accepted != n_queued) @(posedge clk);
    while (due_bytes.size() != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);
  endtask

  initial begin
    rst = 1'b1;
    req_if.valid = 1'b0;
    req_if.kind = KIND_LOAD;
    req_if.symbol = '0;
    req_if.code_word = '0;
    req_if.code_length = '0;
    rsp_if.ready = 1'b0;
    n_queued = 0;
    errors = 0;
    cycle_cnt = 0;
    hold_req_cnt = 0;
    burst_mode = 1'b0;
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // directed: absent symbol, empty flush, unused kind
    queue_item(KIND_ENCODE, 8'd5, 32'h0, 6'd0);
    queue_item(KIND_FLUSH, 8'd0, 32'h0, 6'd0);
    queue_item(KIND_UNUSED, 8'd255, 32'hFFFF_FFFF, 6'd63);
    // table loads: short, byte-sized, odd, full width, overlong, zero-length, wide words
    queue_item(KIND_LOAD, 8'd0, 32'hFFFF_FFFF, 6'd1);
    queue_item(KIND_LOAD, 8'd255, 32'h8000_0001, 6'd32);
    queue_item(KIND_LOAD, 8'd1, 32'h0000_0005, 6'd3);
    queue_item(KIND_LOAD, 8'd2, 32'h0000_00A5, 6'd8);
    queue_item(KIND_LOAD, 8'd3, 32'h0000_01F3, 6'd9);
    queue_item(KIND_LOAD, 8'd4, 32'h7FFF_FFFF, 6'd31);
    queue_item(KIND_LOAD, 8'd6, 32'hDEAD_BEEF, 6'd63);
    queue_item(KIND_LOAD, 8'd7, 32'h1234_5678, 6'd33);
    queue_item(KIND_LOAD, 8'd8, 32'hFFFF_FFFF, 6'd0);
    // encodes across byte boundaries, with flushes
    queue_item(KIND_ENCODE, 8'd0, 32'h0, 6'd0);
    queue_item(KIND_FLUSH, 8'd0, 32'h0, 6'd0);
    queue_item(KIND_ENCODE, 8'd1, 32'h0, 6'd0);
    queue_item(KIND_UNUSED, 8'd1, 32'h0, 6'd0);
    queue_item(KIND_ENCODE, 8'd2, 32'h0, 6'd0);
    queue_item(KIND_ENCODE, 8'd255, 32'h0, 6'd0);
    queue_item(KIND_ENCODE, 8'd8, 32'h0, 6'd0);
    queue_item(KIND_ENCODE, 8'd3, 32'h0, 6'd0);
    queue_item(KIND_ENCODE, 8'd4, 32'h0, 6'd0);
    queue_item(KIND_ENCODE, 8'd6, 32'h0, 6'd0);
    queue_item(KIND_ENCODE, 8'd7, 32'h0, 6'd0);
    queue_item(KIND_FLUSH, 8'd0, 32'h0, 6'd0);
    queue_item(KIND_FLUSH, 8'd0, 32'h0, 6'd0);

    // sender pauses until the block has drained
    wait_drained();

    repeat (45) queue_random_item();
    while (n_accepted != n_queued) @(posedge clk);

    // receiver holds off while full-width codes stream in back to back
    burst_mode = 1'b1;
    hold_req_cnt++;
    for (int i = 0; i < 20; i++)
      queue_item(KIND_ENCODE, (i % 2) ? 8'd255 : 8'd7, 32'h0, 6'd0);
    while (n_accepted != n_queued) @(posedge clk);
    burst_mode = 1'b0;

    repeat (30) queue_random_item();
    queue_item(KIND_FLUSH, 8'd0, 32'h0, 6'd0);
    wait_drained();

    if (errors == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
